// ----- sv/hte_pkg.sv -----
// Package for the table-driven Huffman encoder: field widths, operation codes,
// controller states and default parameter values. No dependencies.
package hte_pkg;

	localparam int OP_W           = 2;
	localparam int SYM_W          = 8;
	localparam int CLEN_W         = 6;
	localparam int CODE_W         = 32;
	localparam int BYTE_W         = 8;
	localparam int TABLE_DEPTH    = 256;
	localparam int IN_TDATA_W     = 48;
	localparam int MAX_CODE_LEN_D = 32;
	localparam int EOT_SYMBOL_D   = 4;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_PACK
	} state_t;

endpackage

// ----- sv/hte_code_table.sv -----
// Code table for the Huffman encoder: one synchronous memory of length and
// code bits, with a valid bit per entry so that reset reads as length zero.
// Depends on hte_pkg.
module hte_code_table #(
	parameter int LEN_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [hte_pkg::SYM_W-1:0]   wr_addr,
	input  logic [LEN_W-1:0]            wr_len,
	input  logic [hte_pkg::CODE_W-1:0]  wr_bits,
	input  logic                        rd_en,
	input  logic [hte_pkg::SYM_W-1:0]   rd_addr,
	output logic [LEN_W-1:0]            rd_len,
	output logic [hte_pkg::CODE_W-1:0]  rd_bits
);
	import hte_pkg::*;

	logic [LEN_W+CODE_W-1:0] mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [LEN_W+CODE_W-1:0] rd_word_q;
	logic                    rd_valid_q;

	// Write an entry and mark it valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_len, wr_bits};
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// An entry never written reads as no code
	assign rd_len  = rd_valid_q ? rd_word_q[LEN_W+CODE_W-1:CODE_W] : '0;
	assign rd_bits = rd_word_q[CODE_W-1:0];

endmodule

// ----- sv/huffman_table_encoder.sv -----
// Table-driven Huffman byte-stream encoder: controller, bit packer and output
// register. Depends on hte_pkg and hte_code_table.
// Usage:
//   Input words arrive on s_axis; tuser carries the operation (load entry,
//   encode byte, finish stream), tdata the symbol, code length and code bits.
//   A load writes one table entry. An encode looks up the
//   byte's code and appends it to the bit packer; a finish appends the code
//   of the end-of-text symbol, pads with zeros to a whole byte and marks the
//   final byte with tlast.
//   Encoded bytes leave on m_axis, earliest bit in the MSB.
// Sequence:
//   A load is written as it is accepted. An encode or finish passes through
//   the accepting step, the table read, a packing step per full byte, one more
//   when code bits are left over and a closing step that also emits any
//   padding byte. The packer works a byte at a time. A finished byte sits in
//   the output register meanwhile.
// Reset: asynchronous reset empties the packer and marks every table entry as
//   having no code; the table needs no clearing pass.
// Stalls: when a byte waits in the output register and m_axis_tready is low,
//   the packer holds; s_axis_tready is low until the current word is fully packed.
module huffman_table_encoder #(
	parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_D,
	parameter int EOT_SYMBOL   = hte_pkg::EOT_SYMBOL_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: symbol [7:0], code_len [13:8], code_bits [45:14], zero [47:46]
	input  logic [hte_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: operation [1:0]
	input  logic [hte_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: out_byte [7:0]
	output logic [hte_pkg::BYTE_W-1:0]      m_axis_tdata,
	output logic                            m_axis_tlast
);
	import hte_pkg::*;

	localparam int LenLimit = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
	localparam int LEN_W    = $clog2(LenLimit + 1);
	localparam int SUM_W    = LEN_W + 1;

	// Input fields
	logic [SYM_W-1:0]  in_symbol;
	logic [CLEN_W-1:0] in_code_len;
	logic [CODE_W-1:0] in_code_bits;
	op_t               in_op;

	assign in_symbol    = s_axis_tdata[SYM_W-1:0];
	assign in_code_len  = s_axis_tdata[SYM_W+CLEN_W-1:SYM_W];
	assign in_code_bits = s_axis_tdata[SYM_W+CLEN_W+CODE_W-1:SYM_W+CLEN_W];
	assign in_op        = op_t'(s_axis_tuser);

	// Table port signals
	logic              tbl_wr_en;
	logic [LEN_W-1:0]  tbl_wr_len;
	logic              tbl_rd_en;
	logic [SYM_W-1:0]  tbl_rd_addr;
	logic [LEN_W-1:0]  tbl_rd_len;
	logic [CODE_W-1:0] tbl_rd_bits;

	// Controller and packer state
	state_t              state_q, state_d;
	logic                fin_q, fin_d;
	logic [LEN_W-1:0]    rem_q, rem_d;
	logic [CODE_W-1:0]   code_q, code_d;
	logic [2:0]          pc_q, pc_d;
	logic [6:0]          pend_q, pend_d;
	logic                out_valid_q, out_valid_d;
	logic [BYTE_W-1:0]   out_byte_q, out_byte_d;
	logic                out_last_q, out_last_d;

	// Packer datapath
	logic                out_free;
	logic [SUM_W-1:0]    sum;
	logic [3:0]          take;
	logic [LEN_W-1:0]    shift_amt;
	logic [CODE_W-1:0]   code_shr;
	logic [BYTE_W-1:0]   take_mask;
	logic [BYTE_W-1:0]   full_byte;
	logic [6:0]          keep_mask;
	logic [6:0]          pend_merged;
	logic [BYTE_W-1:0]   pad_byte;

	// Clamp loaded lengths to the table limit
	assign tbl_wr_len = (in_code_len > CLEN_W'(LenLimit)) ? LEN_W'(LenLimit)
	                                                      : LEN_W'(in_code_len);

	hte_code_table #(
		.LEN_W (LEN_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr_en),
		.wr_addr (in_symbol),
		.wr_len  (tbl_wr_len),
		.wr_bits (in_code_bits),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_len  (tbl_rd_len),
		.rd_bits (tbl_rd_bits)
	);

	// Split the next byte off the pending bits and the remaining code
	assign out_free    = !out_valid_q || m_axis_tready;
	assign sum         = SUM_W'(pc_q) + SUM_W'(rem_q);
	assign take        = 4'd8 - 4'(pc_q);
	assign shift_amt   = rem_q - LEN_W'(take);
	assign code_shr    = code_q >> shift_amt;
	assign take_mask   = BYTE_W'((9'd1 << take) - 9'd1);
	assign full_byte   = (BYTE_W'(pend_q) << take) | (code_shr[BYTE_W-1:0] & take_mask);
	assign keep_mask   = 7'((8'd1 << rem_q) - 8'd1);
	assign pend_merged = 7'(pend_q << rem_q) | (code_q[6:0] & keep_mask);
	assign pad_byte    = BYTE_W'(pend_q) << (4'd8 - 4'(pc_q));

	// Next state and datapath
	always_comb begin
		state_d     = state_q;
		fin_d       = fin_q;
		rem_d       = rem_q;
		code_d      = code_q;
		pc_d        = pc_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_byte_d  = out_byte_q;
		out_last_d  = out_last_q;
		tbl_wr_en   = 1'b0;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = in_symbol;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (in_op)
						OP_LOAD: begin
							tbl_wr_en = 1'b1;
						end
						OP_ENCODE: begin
							tbl_rd_en = 1'b1;
							fin_d     = 1'b0;
							state_d   = ST_LOOKUP;
						end
						OP_FINISH: begin
							tbl_rd_en   = 1'b1;
							tbl_rd_addr = SYM_W'(EOT_SYMBOL);
							fin_d       = 1'b1;
							state_d     = ST_LOOKUP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				rem_d   = tbl_rd_len;
				code_d  = tbl_rd_bits;
				state_d = ST_PACK;
			end
			ST_PACK: begin
				if (out_free) begin
					if (rem_q == '0) begin
						// Code consumed: flush on finish, then return
						if (fin_q && pc_q != 3'd0) begin
							out_valid_d = 1'b1;
							out_byte_d  = pad_byte;
							out_last_d  = 1'b1;
						end
						if (fin_q) begin
							pc_d   = 3'd0;
							pend_d = '0;
						end
						state_d = ST_IDLE;
					end else if (sum >= SUM_W'(BYTE_W)) begin
						// Emit a full byte
						out_valid_d = 1'b1;
						out_byte_d  = full_byte;
						out_last_d  = fin_q && (sum == SUM_W'(BYTE_W));
						rem_d       = shift_amt;
						pc_d        = 3'd0;
						pend_d      = '0;
					end else begin
						// Gather the short remainder
						pend_d = pend_merged;
						pc_d   = sum[2:0];
						rem_d  = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			rem_q       <= '0;
			pc_q        <= 3'd0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fin_q       <= fin_d;
			rem_q       <= rem_d;
			pc_q        <= pc_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		code_q     <= code_d;
		out_byte_q <= out_byte_d;
		out_last_q <= out_last_d;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- verif/huffman_table_encoder_tb.sv -----
// Self-checking testbench for huffman_table_encoder: table loads, byte encodes and
// stream finishes are checked against a bit-level packer prediction.
// Depends on hte_pkg and the huffman_table_encoder RTL.
module huffman_table_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hte_pkg::*;

	// operation code that the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CODE_LIMIT  = (MAX_CODE_LEN_D < CODE_W) ? MAX_CODE_LEN_D : CODE_W;
	localparam int RANDOM_WORDS = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SYM_W-1:0]  sym;
		logic [CLEN_W-1:0] len;
		logic [CODE_W-1:0] bits;
	} enc_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eos;
	} coded_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]      m_axis_tdata;
	logic                   m_axis_tlast;

	// words waiting to be sent, the word on the bus, and bytes still owed by the block
	enc_word_t   send_q[$];
	enc_word_t   word_on_bus;
	coded_byte_t coded_q[$];

	// predicted block state
	logic [CLEN_W-1:0] code_len_tab[TABLE_DEPTH];
	logic [CODE_W-1:0] code_bits_tab[TABLE_DEPTH];
	logic [6:0]        held_bits = '0;
	int                held_count = 0;

	int words_total = 0;
	int words_taken = 0;
	int bytes_checked = 0;
	int streams_closed = 0;
	int errors = 0;
	logic steady;

	huffman_table_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// a stretch of the run with no idling on either side
	assign steady = (words_taken >= 180) && (words_taken < 280);

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic add_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CLEN_W-1:0] len, input logic [CODE_W-1:0] bits);
		enc_word_t w;
		w.op = op;
		w.sym = sym;
		w.len = len;
		w.bits = bits;
		send_q.push_back(w);
		words_total++;
	endtask

	// append one code bit; a full byte goes to the expected stream
	task automatic pack_bit(input logic b);
		if (held_count == 7) begin
			coded_q.push_back('{data: {held_bits, b}, eos: 1'b0});
			held_bits = '0;
			held_count = 0;
		end else begin
			held_bits = {held_bits[5:0], b};
			held_count++;
		end
	endtask

	task automatic pack_code(input logic [SYM_W-1:0] sym);
		int n;
		n = code_len_tab[sym];
		for (int i = n - 1; i >= 0; i--)
			pack_bit(code_bits_tab[sym][i]);
	endtask

	// work out what one accepted word makes the block emit
	task automatic encode_word(input enc_word_t w);
		int prior_size;
		prior_size = coded_q.size();
		case (w.op)
			OP_LOAD: begin
				code_len_tab[w.sym] = (w.len > CODE_LIMIT) ? CLEN_W'(CODE_LIMIT) : w.len;
				code_bits_tab[w.sym] = w.bits;
			end
			OP_ENCODE: pack_code(w.sym);
			OP_FINISH: begin
				pack_code(SYM_W'(EOT_SYMBOL_D));
				while (held_count != 0)
					pack_bit(1'b0);
				if (coded_q.size() > prior_size)
					coded_q[coded_q.size() - 1].eos = 1'b1;
				streams_closed++;
			end
			default: ;
		endcase
	endtask

	// driver: present the next word, with random gaps between words
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		enc_word_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				encode_word(word_on_bus);
				words_taken++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_q.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
					w = send_q.pop_front();
					word_on_bus = w;
					s_axis_tuser <= w.op;
					s_axis_tdata <= {2'b00, w.bits, w.len, w.sym};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each byte taken against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		coded_byte_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (coded_q.size() == 0) begin
					report_error($sformatf("unexpected byte %02h last %0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = coded_q.pop_front();
					if (m_axis_tdata !== want.data)
						report_error($sformatf("byte %0d: data %02h, expected %02h",
							bytes_checked, m_axis_tdata, want.data));
					if (m_axis_tlast !== want.eos)
						report_error($sformatf("byte %0d: tlast %0b, expected %0b",
							bytes_checked, m_axis_tlast, want.eos));
				end
				bytes_checked++;
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 13);
		end
	end

	// stimulus, reset and end of run
	initial begin
		int counted;
		int r;
		logic [SYM_W-1:0] sym;
		logic [CLEN_W-1:0] len;

		for (int i = 0; i < TABLE_DEPTH; i++) begin
			code_len_tab[i] = '0;
			code_bits_tab[i] = '0;
		end

		// directed: empty finishes, missing codes, longest codes, byte boundaries
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);
		add_word(OP_ENCODE, 8'h00, 6'd0, 32'h0);
		add_word(OP_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		add_word(OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
		add_word(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
		add_word(OP_LOAD, 8'h00, 6'd63, 32'h0000_0001);
		add_word(OP_ENCODE, 8'h00, 6'd0, 32'h0);
		add_word(OP_LOAD, SYM_W'(EOT_SYMBOL_D), 6'd3, 32'h0000_0005);
		add_word(OP_LOAD, 8'h41, 6'd5, 32'hABCD_EF16);
		add_word(OP_ENCODE, 8'h41, 6'd0, 32'h0);
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);
		add_word(OP_ENCODE, 8'h41, 6'd0, 32'h0);
		add_word(OP_ENCODE, 8'h41, 6'd0, 32'h0);
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);
		add_word(OP_LOAD, 8'h01, 6'd7, 32'h0);
		add_word(OP_ENCODE, 8'h01, 6'd0, 32'h0);
		add_word(OP_LOAD, SYM_W'(EOT_SYMBOL_D), 6'd40, 32'hA5A5_5A5A);
		add_word(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
		add_word(OP_FINISH, 8'hFF, 6'd63, 32'hFFFF_FFFF);
		add_word(OP_LOAD, SYM_W'(EOT_SYMBOL_D), 6'd0, 32'h1234_5678);
		add_word(OP_ENCODE, 8'h41, 6'd0, 32'h0);
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);
		add_word(OP_LOAD, 8'h80, 6'd1, 32'h0000_0001);
		add_word(OP_ENCODE, 8'h80, 6'd0, 32'h0);

		// random: fill a small working set of codes, then mostly encode streams
		for (int i = 0; i < 16; i++)
			add_word(OP_LOAD, SYM_W'(i), CLEN_W'($urandom_range(9, 1)), $urandom());
		counted = 16;
		while (counted < RANDOM_WORDS) begin
			r = $urandom_range(99);
			sym = ($urandom_range(99) < 75) ? SYM_W'($urandom_range(15)) : SYM_W'($urandom());
			if (r < 15) begin
				case ($urandom_range(19))
					0, 1:    len = 6'd0;
					2, 3:    len = CLEN_W'($urandom_range(32, 10));
					4:       len = CLEN_W'($urandom_range(63, 33));
					default: len = CLEN_W'($urandom_range(9, 1));
				endcase
				add_word(OP_LOAD, sym, len, $urandom());
			end else if (r < 87) begin
				add_word(OP_ENCODE, sym, CLEN_W'($urandom()), $urandom());
			end else if (r < 97) begin
				add_word(OP_FINISH, SYM_W'($urandom()), CLEN_W'($urandom()), $urandom());
			end else begin
				add_word(OP_UNUSED, SYM_W'($urandom()), CLEN_W'($urandom()), $urandom());
				counted--;
			end
			counted++;
		end
		add_word(OP_FINISH, 8'h00, 6'd0, 32'h0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// hold until every word is taken and every byte has come out
		while (words_taken < words_total)
			@(posedge clk);
		while (coded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (coded_q.size() != 0)
			report_error($sformatf("%0d expected bytes never arrived", coded_q.size()));

		$display("Sent %0d words (table loads, encodes, %0d stream finishes).",
			words_taken, streams_closed);
		$display("Compared %0d encoded bytes with tlast; %0d mismatches.",
			bytes_checked, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#2_400_000;
		$display("Timeout: %0d of %0d words taken, %0d bytes outstanding",
			words_taken, words_total, coded_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
